// ===== design/mcss_pkg.sv =====
// Shared types, constants and a helper function of the MIDI clock step sequencer.
package mcss_pkg;

  // Sequencer geometry
  localparam int STEP_COUNT         = 8;
  localparam int PULSES_PER_QUARTER = 24;
  localparam int KEY_TABLE_SIZE     = 8;
  localparam int KEY_ENTRIES        = (STEP_COUNT < KEY_TABLE_SIZE) ? STEP_COUNT : KEY_TABLE_SIZE;

  // Field widths
  localparam int STEP_W      = $clog2(STEP_COUNT + 1);
  localparam int TICK_W      = $clog2(PULSES_PER_QUARTER + 1);
  localparam int NOTE_W      = 7;
  localparam int CHAN_W      = 5;
  localparam int TABLE_W     = NOTE_W * KEY_TABLE_SIZE;
  localparam int CFG_IDX_W   = 2;
  localparam int PW_W        = 10;
  localparam int DIV_IDX_W   = 3;
  localparam int OUT_STEP_W  = 4;

  // Shared divide unit geometry: dividend sized for cc_value * 1000, divisor sized for 127
  localparam int DIVIDEND_W  = 17;
  localparam int DIVISOR_W   = 7;

  // Controller scaling
  localparam int CC_FULL_SCALE  = 127;
  localparam int PW_FULL_SCALE  = 1000;
  localparam int DIV_STEPS      = 7;
  localparam int DIV_IDX_MAX    = 6;

  // Clock ticks per step for each division setting (1, 2, 3, 4, 6, 8, 12)
  localparam logic [TICK_W-1:0] PERIOD_TABLE [DIV_STEPS] = '{
    TICK_W'(PULSES_PER_QUARTER / 1),
    TICK_W'(PULSES_PER_QUARTER / 2),
    TICK_W'(PULSES_PER_QUARTER / 3),
    TICK_W'(PULSES_PER_QUARTER / 4),
    TICK_W'(PULSES_PER_QUARTER / 6),
    TICK_W'(PULSES_PER_QUARTER / 8),
    TICK_W'(PULSES_PER_QUARTER / 12)
  };

  typedef enum logic [2:0] {
    CMD_CLOCK    = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_CONTINUE = 3'd3,
    CMD_NOTE_ON  = 3'd4,
    CMD_MODE     = 3'd5,
    CMD_SYNC     = 3'd6,
    CMD_CONTROL  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_UNKNOWN  = 2'd0,
    MODE_CLOCK    = 2'd1,
    MODE_KEYBOARD = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LED_UNCHANGED = 2'd0,
    LED_GREEN     = 2'd1,
    LED_OFF       = 2'd2
  } led_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KEYBOARD_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_KEY_TABLE   = 2'd1;

  localparam logic [NOTE_W-1:0] CC_PULSE_WIDTH = 7'd82;
  localparam logic [NOTE_W-1:0] CC_DIVISION    = 7'd83;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_EMIT
  } state_t;

  // Divider request and response; fold selects the shortcut for a divisor of 2^7 - 1
  typedef struct packed {
    logic                  start;
    logic                  fold;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

  // Advance pulses needed to go from step 'from' to the step before 'to'
  function automatic logic [STEP_W-1:0] steps_needed(input logic [STEP_W-1:0] from,
                                                     input logic [STEP_W-1:0] to);
    logic [STEP_W:0] d;
    if (from == '0 || from == to) begin
      d = (STEP_W+1)'(STEP_COUNT - 1);
    end else if (to < from) begin
      d = (STEP_W+1)'(STEP_COUNT) + {1'b0, to} - {1'b0, from} - (STEP_W+1)'(1);
    end else begin
      d = {1'b0, to} - {1'b0, from} - (STEP_W+1)'(1);
    end
    return d[STEP_W-1:0];
  endfunction

endpackage

// ===== design/mcss_if.sv =====
// Channel interfaces: event input, result output and configuration writes.
interface mcss_item_if;
  import mcss_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [CHAN_W-1:0] channel;
  logic [NOTE_W-1:0] note;
  logic [NOTE_W-1:0] velocity;
  logic [NOTE_W-1:0] cc_number;
  logic [NOTE_W-1:0] cc_value;
  logic              switch_level;

  modport source (output valid, cmd, channel, note, velocity, cc_number, cc_value,
                  switch_level, input ready);
  modport sink   (input valid, cmd, channel, note, velocity, cc_number, cc_value,
                  switch_level, output ready);
endinterface

interface mcss_result_if;
  import mcss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [3:0]            advance_pulses;
  logic [PW_W-1:0]       pulse_width;
  logic [OUT_STEP_W-1:0] current_step;
  logic [1:0]            led_command;
  logic                  duty_write;
  logic [7:0]            duty_value;

  modport source (output valid, advance_pulses, pulse_width, current_step, led_command,
                  duty_write, duty_value, input ready);
  modport sink   (input valid, advance_pulses, pulse_width, current_step, led_command,
                  duty_write, duty_value, output ready);
endinterface

interface mcss_cfg_if;
  import mcss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TABLE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/midi_clock_step_sequencer_top.sv =====
// An event goes through EXEC, DIV for a clock tick while following outside keyboard mode
// and for the width and division controllers, EMIT and the output register. DIV takes up to
// 3 divide unit steps for a controller, one per period subtracted for a tick (0 or 1, up to 12
// after a division change). Events are taken only in IDLE; a stalled result holds EMIT.
// Reset (rst, synchronous): mode unknown, not following, step 0, tick 0, division 1,
// pulse width 0, keyboard channel 1, key table cleared; not ready while rst is high.
module midi_clock_step_sequencer_top
  import mcss_pkg::*;
(
  input logic           clk,
  input logic           rst,
  mcss_item_if.sink     item,
  mcss_result_if.source result,
  mcss_cfg_if.sink      cfg
);

  state_t state, state_next;

  // Configuration registers
  logic [CHAN_W-1:0]    keyboard_channel;
  logic [TABLE_W-1:0]   step_key_table;

  // Sequencer state
  mode_t                mode;
  logic                 following_clock;
  logic [TICK_W-1:0]    tick_count;
  logic [STEP_W-1:0]    step_position;
  logic [DIV_IDX_W-1:0] division_index;
  logic [PW_W-1:0]      pulse_width_ticks;

  // Latched event
  cmd_t                 cmd_q;
  logic [CHAN_W-1:0]    channel_q;
  logic [NOTE_W-1:0]    note_q;
  logic [NOTE_W-1:0]    velocity_q;
  logic [NOTE_W-1:0]    cc_number_q;
  logic [NOTE_W-1:0]    cc_value_q;
  logic                 level_q;

  // Pending result
  logic [STEP_W-1:0]    res_pulses;
  led_t                 res_led;
  logic                 res_duty_write;
  logic [7:0]           res_duty_value;

  // Output register
  logic                  out_valid;
  logic [3:0]            out_pulses;
  logic [PW_W-1:0]       out_pw;
  logic [OUT_STEP_W-1:0] out_step;
  led_t                  out_led;
  logic                  out_duty_write;
  logic [7:0]            out_duty_value;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic item_fire;
  logic out_free;
  logic keyboard_mode;
  logic need_div;
  logic [STEP_W-1:0] key_target;
  mode_t wanted_mode;

  assign item_fire     = item.valid && item.ready;
  assign out_free      = !out_valid || result.ready;
  assign keyboard_mode = (mode == MODE_KEYBOARD);
  assign wanted_mode   = level_q ? MODE_CLOCK : MODE_KEYBOARD;

  assign need_div = ((cmd_q == CMD_CLOCK) && following_clock && !keyboard_mode) ||
                    ((cmd_q == CMD_CONTROL) &&
                     (cc_number_q == CC_PULSE_WIDTH || cc_number_q == CC_DIVISION));

  // Key table search, lowest matching entry wins
  always_comb begin
    key_target = '0;
    for (int i = KEY_ENTRIES - 1; i >= 0; i--) begin
      if (step_key_table[NOTE_W*i +: NOTE_W] == note_q) begin
        key_target = STEP_W'(i + 1);
      end
    end
  end

  // Divider operand selection
  always_comb begin
    div_req.start    = (state == S_EXEC) && need_div;
    div_req.fold     = 1'b0;
    div_req.dividend = DIVIDEND_W'(tick_count);
    div_req.divisor  = DIVISOR_W'(PERIOD_TABLE[division_index]);
    if (cmd_q == CMD_CONTROL) begin
      div_req.fold    = 1'b1;
      div_req.divisor = DIVISOR_W'(CC_FULL_SCALE);
      if (cc_number_q == CC_PULSE_WIDTH) begin
        div_req.dividend = DIVIDEND_W'(cc_value_q) * DIVIDEND_W'(PW_FULL_SCALE);
      end else begin
        div_req.dividend = DIVIDEND_W'(cc_value_q) * DIVIDEND_W'(DIV_STEPS);
      end
    end
  end

  mcss_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item.ready = !rst;
        if (item.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration writes
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyboard_channel <= CHAN_W'(1);
      step_key_table   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_KEYBOARD_CHANNEL: keyboard_channel <= cfg.data[CHAN_W-1:0];
        CFG_STEP_KEY_TABLE:   step_key_table   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Latch the event transaction
  always_ff @(posedge clk) begin
    if (item_fire) begin
      cmd_q       <= cmd_t'(item.cmd);
      channel_q   <= item.channel;
      note_q      <= item.note;
      velocity_q  <= item.velocity;
      cc_number_q <= item.cc_number;
      cc_value_q  <= item.cc_value;
      level_q     <= item.switch_level;
    end
  end

  // Event execution and sequencer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_UNKNOWN;
      following_clock   <= 1'b0;
      tick_count        <= '0;
      step_position     <= '0;
      division_index    <= '0;
      pulse_width_ticks <= '0;
    end else if (state == S_EXEC && !need_div) begin
      res_pulses     <= '0;
      res_led        <= LED_UNCHANGED;
      res_duty_write <= 1'b0;
      res_duty_value <= '0;
      unique case (cmd_q)
        CMD_START: begin
          if (!keyboard_mode) begin
            res_pulses      <= steps_needed(step_position, STEP_W'(1));
            following_clock <= 1'b1;
            tick_count      <= '0;
            step_position   <= '0;
          end
        end
        CMD_STOP:     following_clock <= 1'b0;
        CMD_CONTINUE: following_clock <= 1'b1;
        CMD_NOTE_ON: begin
          if (keyboard_mode && channel_q == keyboard_channel && key_target != '0) begin
            res_duty_write <= 1'b1;
            res_duty_value <= {velocity_q, 1'b0};
            res_pulses     <= steps_needed(step_position, key_target) + STEP_W'(1);
            step_position  <= key_target;
          end
        end
        CMD_MODE: begin
          if (wanted_mode != mode) begin
            mode       <= wanted_mode;
            tick_count <= '0;
            res_pulses <= steps_needed(step_position, STEP_W'(1)) + STEP_W'(1);
            if (wanted_mode == MODE_CLOCK) begin
              step_position <= '0;
            end else begin
              following_clock <= 1'b0;
              step_position   <= STEP_W'(1);
            end
          end
        end
        CMD_SYNC: begin
          if (!level_q) begin
            step_position <= STEP_W'(1);
          end
        end
        default: ;  // idle clock ticks and other controllers
      endcase
    end else if (state == S_DIV && div_rsp.done) begin
      res_pulses     <= '0;
      res_led        <= LED_UNCHANGED;
      res_duty_write <= 1'b0;
      res_duty_value <= '0;
      if (cmd_q == CMD_CLOCK) begin
        // remainder of tick_count by the period, plus one
        tick_count <= TICK_W'(div_rsp.remainder) + TICK_W'(1);
        if (div_rsp.remainder == '0) begin
          step_position <= (step_position == STEP_W'(STEP_COUNT)) ? STEP_W'(1)
                                                                  : step_position + STEP_W'(1);
          res_pulses    <= STEP_W'(1);
          res_led       <= LED_GREEN;
        end else begin
          res_led <= LED_OFF;
        end
      end else if (cc_number_q == CC_PULSE_WIDTH) begin
        pulse_width_ticks <= div_rsp.quotient[PW_W-1:0];
      end else begin
        division_index <= (div_rsp.quotient > DIVIDEND_W'(DIV_IDX_MAX)) ?
                          DIV_IDX_W'(DIV_IDX_MAX) : div_rsp.quotient[DIV_IDX_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_pulses     <= 4'(res_pulses);
      out_pw         <= pulse_width_ticks;
      out_step       <= OUT_STEP_W'(step_position);
      out_led        <= res_led;
      out_duty_write <= res_duty_write;
      out_duty_value <= res_duty_value;
    end
  end

  assign result.valid          = out_valid;
  assign result.advance_pulses = out_pulses;
  assign result.pulse_width    = out_pw;
  assign result.current_step   = out_step;
  assign result.led_command    = out_led;
  assign result.duty_write     = out_duty_write;
  assign result.duty_value     = out_duty_value;

`ifndef NO_ASSERTIONS
  // An accepted event is always executed in the following cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> state == S_EXEC)
    else $error("accepted transaction not executed");

  // The divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  // Step position stays within the sequence
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_position <= STEP_W'(STEP_COUNT))
    else $error("step position out of range");

  // Tick count never passes one quarter note
  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_count <= TICK_W'(PULSES_PER_QUARTER))
    else $error("tick count out of range");
`endif

endmodule

// ===== design/mcss_divider.sv =====
// Shared iterative divide unit: high-part folding for 127, then compare and subtract.
module mcss_divider
  import mcss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic                  fold;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dsr;

  // One step per cycle: 128*h + l leaves h + l mod 127, so fold while h is nonzero,
  // then subtract the divisor while it still fits
  logic [DIVIDEND_W-1:0] rem_hi;
  logic [DIVIDEND_W-1:0] rem_lo;
  logic [DIVIDEND_W-1:0] dsr_ext;
  logic                  do_fold;
  logic                  do_sub;

  assign rem_hi  = {{DIVISOR_W{1'b0}}, rem[DIVIDEND_W-1:DIVISOR_W]};
  assign rem_lo  = {{(DIVIDEND_W-DIVISOR_W){1'b0}}, rem[DIVISOR_W-1:0]};
  assign dsr_ext = {{(DIVIDEND_W-DIVISOR_W){1'b0}}, dsr};
  assign do_fold = fold && (rem_hi != '0);
  assign do_sub  = rem >= dsr_ext;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && !do_fold && !do_sub;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && !do_fold && !do_sub) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      fold <= req.fold;
      rem  <= req.dividend;
      quo  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      if (do_fold) begin
        rem <= rem_lo + rem_hi;
        quo <= quo + rem_hi;
      end else if (do_sub) begin
        rem <= rem - dsr_ext;
        quo <= quo + DIVIDEND_W'(1);
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[DIVISOR_W-1:0];

endmodule
